// ===== hdl/psp_pkg.sv =====
package psp_pkg;

	localparam int SLOTS_DEF       = 8;
	localparam int PRIME_SLOTS_DEF = 4;
	localparam int DESC_PER_SLOT   = 3;
	localparam int PERIOD_LEN_MAX  = 4096;

	localparam int OP_W     = 2;
	localparam int BYTES_W  = 16;
	localparam int ID_W     = 16;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 3;
	localparam int COUNT_W  = 4;
	localparam int DROP_W   = 32;
	localparam int USABLE_W = 4;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 48;

	localparam logic [OP_W-1:0] OP_SUBMIT  = 2'd0;
	localparam logic [OP_W-1:0] OP_RECLAIM = 2'd1;
	localparam logic [OP_W-1:0] OP_PRIME   = 2'd2;
	localparam logic [OP_W-1:0] OP_RESET   = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BADLEN  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DROP    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NONE    = 3'd4;

	localparam logic [USABLE_W-1:0] USABLE_RST = 4'd8;

endpackage

// ===== hdl/psp_pick.sv =====
module psp_pick #(
	parameter int SLOTS = psp_pkg::SLOTS_DEF
) (
	input  logic [SLOTS-1:0]                          free,
	output logic                                      found,
	output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] idx
);

	localparam int SW = SLOTS > 1 ? $clog2(SLOTS) : 1;

	// lowest set bit wins
	always_comb begin
		idx = '0;
		for (int k = SLOTS - 1; k >= 0; k--) begin
			if (free[k]) begin
				idx = SW'(k);
			end
		end
		found = |free;
	end

endmodule

// ===== hdl/period_slot_pool_unit.sv =====
// Slot allocator for a pool of transmit period slots, one busy bit per slot.
// Submit, reclaim and pool reset each give one result; a prime gives one
// result per cycle unless the output stalls, one per filled slot (at most
// PRIME_SLOTS, or one ST_NONE if none is free), as each fill uses the single
// lowest-free picker and sees the slots taken before it. The input is blocked
// during a prime until its last result is registered, and otherwise taken
// every cycle while the result register drains. No clearing pass after reset.
module period_slot_pool_unit #(
	parameter int SLOTS       = psp_pkg::SLOTS_DEF,
	parameter int PRIME_SLOTS = psp_pkg::PRIME_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// op[1:0], period_len[17:2], used_id[33:18], zero fill
	input  logic [psp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// status[2:0], slot[5:3], slot_valid[6], in_flight[10:7], drop_total[42:11]
	output logic [psp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	output logic                             m_axis_tlast,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [psp_pkg::USABLE_W-1:0]     cfg_data
);

	localparam int SW     = SLOTS > 1 ? $clog2(SLOTS) : 1;
	localparam int PCW    = PRIME_SLOTS > 1 ? $clog2(PRIME_SLOTS) : 1;
	localparam int ID_LIM = SLOTS * psp_pkg::DESC_PER_SLOT;
	localparam int IDW    = $clog2(ID_LIM + 1);

	// input stage
	logic                          act_s1;
	logic [psp_pkg::OP_W-1:0]      op_s1;
	logic [psp_pkg::BYTES_W-1:0]   bytes_s1;
	logic [psp_pkg::ID_W-1:0]      id_s1;
	logic [PCW-1:0]                pcnt_s1;

	// pool state
	logic [SLOTS-1:0]              busy_q;
	logic [psp_pkg::COUNT_W-1:0]   count_q;
	logic [psp_pkg::DROP_W-1:0]    drop_q;
	logic [psp_pkg::USABLE_W-1:0]  usable_q;

	// result register
	logic                          m_valid_q;
	logic [psp_pkg::STATUS_W-1:0]  status_q;
	logic [psp_pkg::SLOT_W-1:0]    slot_q;
	logic                          slot_valid_q;
	logic [psp_pkg::COUNT_W-1:0]   flight_q;
	logic [psp_pkg::DROP_W-1:0]    drop_out_q;
	logic                          last_q;

	logic                          in_acc;
	logic                          adv;
	logic [4:0]                    lim;
	logic [SLOTS-1:0]              free;
	logic                          found;
	logic [SW-1:0]                 pick_idx;
	logic [SLOTS-1:0]              pick_1h;
	logic [IDW-1:0]                id_n;
	logic                          id_in_range;
	logic [SW-1:0]                 rec_idx;
	logic                          bad_len;

	logic [SLOTS-1:0]              busy_d;
	logic [psp_pkg::COUNT_W-1:0]   count_d;
	logic [psp_pkg::DROP_W-1:0]    drop_d;
	logic [psp_pkg::STATUS_W-1:0]  res_status;
	logic [SW-1:0]                 res_idx;
	logic                          res_valid;
	logic                          res_last;

	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign adv           = act_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !act_s1 || (adv && res_last);
	assign cfg_ready     = 1'b1;

	assign lim = ({1'b0, usable_q} > 5'(SLOTS)) ? 5'(SLOTS) : {1'b0, usable_q};

	always_comb begin
		for (int k = 0; k < SLOTS; k++) begin
			free[k] = !busy_q[k] && (5'(k) < lim);
		end
	end

	psp_pick #(
		.SLOTS (SLOTS)
	) u_pick (
		.free  (free),
		.found (found),
		.idx   (pick_idx)
	);

	assign pick_1h = SLOTS'(1) << pick_idx;

	// id / DESC_PER_SLOT over the narrow in-range part
	assign id_in_range = id_s1 < psp_pkg::ID_W'(ID_LIM);
	assign id_n        = id_s1[IDW-1:0];

	always_comb begin
		rec_idx = '0;
		for (int k = 1; k < SLOTS; k++) begin
			if (id_n >= IDW'(k * psp_pkg::DESC_PER_SLOT)) begin
				rec_idx = SW'(k);
			end
		end
	end

	assign bad_len = (bytes_s1 == '0) ||
		(bytes_s1 > psp_pkg::BYTES_W'(psp_pkg::PERIOD_LEN_MAX));

	always_comb begin
		busy_d     = busy_q;
		count_d    = count_q;
		drop_d     = drop_q;
		res_status = psp_pkg::ST_OK;
		res_idx    = '0;
		res_valid  = 1'b0;
		res_last   = 1'b1;
		case (op_s1)
			psp_pkg::OP_SUBMIT: begin
				if (bad_len) begin
					res_status = psp_pkg::ST_BADLEN;
				end else if (found) begin
					busy_d    = busy_q | pick_1h;
					count_d   = (count_q == '1) ? count_q : count_q + 1'b1;
					res_idx   = pick_idx;
					res_valid = 1'b1;
				end else begin
					drop_d     = drop_q + 1'b1;
					res_status = psp_pkg::ST_DROP;
				end
			end
			psp_pkg::OP_RECLAIM: begin
				if (id_in_range && busy_q[rec_idx]) begin
					busy_d    = busy_q & ~(SLOTS'(1) << rec_idx);
					count_d   = (count_q == '0) ? count_q : count_q - 1'b1;
					res_idx   = rec_idx;
					res_valid = 1'b1;
				end else begin
					res_status = psp_pkg::ST_IGNORED;
				end
			end
			psp_pkg::OP_PRIME: begin
				if (found) begin
					busy_d    = busy_q | pick_1h;
					count_d   = (count_q == '1) ? count_q : count_q + 1'b1;
					res_idx   = pick_idx;
					res_valid = 1'b1;
					res_last  = (pcnt_s1 == PCW'(PRIME_SLOTS - 1)) || ((free & ~pick_1h) == '0);
				end else begin
					res_status = psp_pkg::ST_NONE;
				end
			end
			psp_pkg::OP_RESET: begin
				busy_d  = '0;
				count_d = '0;
				drop_d  = '0;
			end
			default: begin
				res_status = psp_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1    <= 1'b0;
			pcnt_s1   <= '0;
			busy_q    <= '0;
			count_q   <= '0;
			drop_q    <= '0;
			usable_q  <= psp_pkg::USABLE_RST;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				usable_q <= cfg_data;
			end
			if (in_acc) begin
				act_s1  <= 1'b1;
				pcnt_s1 <= '0;
			end else if (adv && res_last) begin
				act_s1 <= 1'b0;
			end else if (adv) begin
				pcnt_s1 <= pcnt_s1 + 1'b1;
			end
			if (adv) begin
				busy_q  <= busy_d;
				count_q <= count_d;
				drop_q  <= drop_d;
			end
			if (adv) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1    <= s_axis_tdata[1:0];
			bytes_s1 <= s_axis_tdata[17:2];
			id_s1    <= s_axis_tdata[33:18];
		end
		if (adv) begin
			status_q     <= res_status;
			slot_q       <= res_valid ? psp_pkg::SLOT_W'(32'(res_idx)) : '0;
			slot_valid_q <= res_valid;
			flight_q     <= count_d;
			drop_out_q   <= drop_d;
			last_q       <= res_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tlast  = last_q;
	assign m_axis_tdata  = {5'd0, drop_out_q, flight_q, slot_valid_q, slot_q, status_q};

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == psp_pkg::COUNT_W'($countones(busy_q)) || count_q == '1)
		else $error("busy count out of step with busy map");

	a_take_marks_busy: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res_valid && (op_s1 == psp_pkg::OP_SUBMIT || op_s1 == psp_pkg::OP_PRIME)
		|=> busy_q[$past(res_idx)])
		else $error("allocated slot not marked busy");

	a_prime_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		act_s1 && !res_last |-> !s_axis_tready)
		else $error("input taken mid prime");

	a_reset_op_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && op_s1 == psp_pkg::OP_RESET |=> busy_q == '0 && drop_q == '0 && count_q == '0)
		else $error("reset op left state behind");

endmodule
